// ===== sv/run_end_filter_coalescer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the run-end filter coalescer
// Shared checking helpers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RUN_END_FILTER_COALESCER_CORE_ASSERT_SVH
`define RUN_END_FILTER_COALESCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define REFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define REFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/refc_pkg.sv =====
// ----------------------------------------------------------------------------
// Run-end filter coalescer package
// Default sizes, stream field widths and shared types of the coalescer.
// ----------------------------------------------------------------------------
package refc_pkg;

	localparam int VALUE_BITS_DEF   = 64;
	localparam int RUN_END_BITS_DEF = 32;

	// Fixed widths of the stream fields.
	localparam int VALUE_WORD_W = 64;
	localparam int SEG_LEN_W    = 32;
	localparam int IN_TDATA_W   = 96;
	localparam int IN_TUSER_W   = 3;

	// Which of the two possible results of a segment is being delivered.
	typedef enum logic {
		SEL_CLOSE = 1'b0,
		SEL_FLUSH = 1'b1
	} res_sel_t;

	// Flags of one result, run_valid in bit 0.
	typedef struct packed {
		logic overflow;
		logic last_of_item;
		logic has_run;
		logic run_valid;
	} out_flags_t;

	localparam int OUT_TUSER_W = $bits(out_flags_t);

endpackage

// ===== sv/run_end_filter_coalescer_core.sv =====
// ----------------------------------------------------------------------------
// Run-end filter coalescer core
// Filters merged run-end-encoded segments and re-merges the survivors into
// maximal runs. A segment is taken every cycle unless the output stalls; its
// open-run update is one compare and one saturating add into a stage register,
// and the trailing-run flush add sits between that stage and the output
// register. The output register delivers one result per cycle while m_tready
// is high, so a last segment that also closes a run holds the input until both
// its results are loaded; every other segment sustains one per cycle unstalled.
// ----------------------------------------------------------------------------
module run_end_filter_coalescer_core
	import refc_pkg::*;
#(
	parameter int VALUE_BITS   = VALUE_BITS_DEF,
	parameter int RUN_END_BITS = RUN_END_BITS_DEF,
	localparam int OUT_TDATA_W = ((RUN_END_BITS + VALUE_WORD_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write: null_mode.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data,
	// Segment stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // value_word[63:0], segment_length[95:64]
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // value_valid, filter_valid, filter_select
	input  logic                   s_tlast,  // last_segment
	// Run stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // run_end, run_value (64), zero fill
	output logic [OUT_TUSER_W-1:0] m_tuser,  // run_valid, has_run, last_of_item, overflow
	output logic                   m_tlast   // end_of_stream
);

	localparam int RB = RUN_END_BITS;
	localparam int VB = VALUE_BITS;
	localparam int LW = (RUN_END_BITS > SEG_LEN_W) ? RUN_END_BITS : SEG_LEN_W;

	// Configuration and run state.
	logic          null_mode_q;
	logic [RB-1:0] open_len_q;
	logic          open_null_q;
	logic [VB-1:0] open_val_q;
	logic [RB-1:0] closed_end_q;
	logic          ovf_q;

	// Stage 1: one segment with its close result and the state to flush.
	logic          vld_s1;
	logic          a_vld_s1;
	logic [RB-1:0] a_end_s1;
	logic [VB-1:0] a_val_s1;
	logic          a_valid_s1;
	logic          a_ovf_s1;
	logic          last_s1;
	logic [RB-1:0] f_len_s1;
	logic          f_null_s1;
	logic [VB-1:0] f_val_s1;
	logic [RB-1:0] f_base_s1;
	logic          f_ovf_s1;
	res_sel_t      sel_q;

	// Output register.
	logic                   m_tvalid_q;
	logic [RB-1:0]          out_end_q;
	logic [VALUE_WORD_W-1:0] out_val_q;
	out_flags_t             out_flags_q;
	logic                   out_eos_q;

	// Input decode.
	logic [VB-1:0] in_val;
	logic          in_vvalid, in_fvalid, in_fsel;
	logic [LW-1:0] len_w;
	logic          len_ovf;
	logic [RB-1:0] len_r;
	logic          emit, act, is_null, close_req, extend;
	logic [RB:0]   c_sum, e_sum;
	logic          a_vld;
	logic [RB-1:0] closed_end1, open_len1;
	logic          open_null1, ovf1;
	logic [VB-1:0] open_val1;
	logic          s_accept;

	// Flush and delivery.
	logic [RB:0]   f_sum;
	logic          f_has;
	logic [RB-1:0] b_end;
	logic          b_ovf, b_valid;
	logic          pend_a, has_res, out_load, s1_free;
	logic [RB-1:0] r_end;
	logic [VB-1:0] r_val;
	out_flags_t    r_flags;
	logic          r_eos;

	assign cfg_ready = 1'b1;

	assign in_val    = s_tdata[VB-1:0];
	assign in_vvalid = s_tuser[0];
	assign in_fvalid = s_tuser[1];
	assign in_fsel   = s_tuser[2];

	always_comb begin
		len_w   = LW'(s_tdata[IN_TDATA_W-1:VALUE_WORD_W]);
		len_ovf = len_w > LW'({RB{1'b1}});
		len_r   = len_ovf ? {RB{1'b1}} : len_w[RB-1:0];

		emit    = in_fvalid ? in_fsel : null_mode_q;
		act     = emit && (len_w != '0);
		is_null = !in_fvalid || !in_vvalid;
		if (is_null) begin
			close_req = act && !open_null_q;
		end else begin
			close_req = act && (open_null_q || (open_len_q == '0) || (open_val_q != in_val));
		end
		extend = act && !close_req;

		c_sum = {1'b0, closed_end_q} + {1'b0, open_len_q};
		e_sum = {1'b0, open_len_q} + {1'b0, len_r};
		a_vld = close_req && (open_len_q != '0);

		closed_end1 = closed_end_q;
		if (a_vld) begin
			closed_end1 = c_sum[RB] ? {RB{1'b1}} : c_sum[RB-1:0];
		end

		open_len1  = open_len_q;
		open_null1 = open_null_q;
		open_val1  = open_val_q;
		if (close_req) begin
			open_len1  = len_r;
			open_null1 = is_null;
			if (!is_null) begin
				open_val1 = in_val;
			end
		end else if (extend) begin
			open_len1 = e_sum[RB] ? {RB{1'b1}} : e_sum[RB-1:0];
		end

		ovf1 = ovf_q || (s_tvalid && len_ovf && emit) || len_ovf
			|| (a_vld && c_sum[RB]) || (extend && e_sum[RB]);
	end

	// Delivery of the stage-1 results, close result first.
	always_comb begin
		f_sum   = {1'b0, f_base_s1} + {1'b0, f_len_s1};
		f_has   = f_len_s1 != '0;
		b_end   = !f_has ? f_base_s1 : (f_sum[RB] ? {RB{1'b1}} : f_sum[RB-1:0]);
		b_ovf   = f_ovf_s1 || (f_has && f_sum[RB]);
		b_valid = f_has && !f_null_s1;

		pend_a   = vld_s1 && a_vld_s1 && (sel_q == SEL_CLOSE);
		has_res  = pend_a || (vld_s1 && last_s1);
		out_load = has_res && (!m_tvalid_q || m_tready);
		s1_free  = !vld_s1 || !has_res || (out_load && !(pend_a && last_s1));

		if (pend_a) begin
			r_end                = a_end_s1;
			r_val                = a_valid_s1 ? a_val_s1 : '0;
			r_flags.run_valid    = a_valid_s1;
			r_flags.has_run      = 1'b1;
			r_flags.last_of_item = !last_s1;
			r_flags.overflow     = a_ovf_s1;
			r_eos                = 1'b0;
		end else begin
			r_end                = b_end;
			r_val                = b_valid ? f_val_s1 : '0;
			r_flags.run_valid    = b_valid;
			r_flags.has_run      = f_has;
			r_flags.last_of_item = 1'b1;
			r_flags.overflow     = b_ovf;
			r_eos                = 1'b1;
		end
	end

	assign s_tready = s1_free;
	assign s_accept = s_tvalid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			null_mode_q <= cfg_data;
		end
	end

	// Run state; a last segment returns it to the start of a new stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_len_q   <= '0;
			open_null_q  <= 1'b1;
			open_val_q   <= '0;
			closed_end_q <= '0;
			ovf_q        <= 1'b0;
		end else if (s_accept) begin
			if (s_tlast) begin
				open_len_q   <= '0;
				open_null_q  <= 1'b1;
				open_val_q   <= '0;
				closed_end_q <= '0;
				ovf_q        <= 1'b0;
			end else begin
				open_len_q   <= open_len1;
				open_null_q  <= open_null1;
				open_val_q   <= open_val1;
				closed_end_q <= closed_end1;
				ovf_q        <= ovf1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			a_vld_s1 <= 1'b0;
			last_s1  <= 1'b0;
			sel_q    <= SEL_CLOSE;
		end else begin
			if (s1_free) begin
				vld_s1   <= s_accept;
				a_vld_s1 <= a_vld;
				last_s1  <= s_tlast;
				sel_q    <= SEL_CLOSE;
			end else if (out_load && pend_a) begin
				sel_q <= SEL_FLUSH;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			a_end_s1   <= closed_end1;
			a_val_s1   <= open_val_q;
			a_valid_s1 <= !open_null_q;
			a_ovf_s1   <= ovf1;
			f_len_s1   <= open_len1;
			f_null_s1  <= open_null1;
			f_val_s1   <= open_val1;
			f_base_s1  <= closed_end1;
			f_ovf_s1   <= ovf1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_end_q   <= r_end;
			out_val_q   <= VALUE_WORD_W'(r_val);
			out_flags_q <= r_flags;
			out_eos_q   <= r_eos;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({out_val_q, out_end_q});
	assign m_tuser  = out_flags_q;
	assign m_tlast  = out_eos_q;

`include "run_end_filter_coalescer_core_assert.svh"

	`REFC_ASSERT_IMP(a_flush_sel, sel_q == SEL_FLUSH, vld_s1 && last_s1 && a_vld_s1, "flush selected without a pending close")
	`REFC_ASSERT_IMP(a_bare_marker, m_tvalid && !out_flags_q.has_run, out_eos_q && !out_flags_q.run_valid && (out_val_q == '0), "bare marker outside stream end")
	`REFC_ASSERT_IMP(a_eos_last, m_tvalid && out_eos_q, out_flags_q.last_of_item, "stream end not last result of its segment")
	`REFC_ASSERT_NXT(a_stream_reset, s_accept && s_tlast, (open_len_q == '0) && (closed_end_q == '0) && !ovf_q && open_null_q, "run state not cleared after last segment")

endmodule

// ===== tb/sv/run_end_filter_coalescer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Run-end filter coalescer core testbench
// Feeds merged filter segments through the segment stream and checks every
// emitted run against a cycle-free model of the coalescer. A directed opening
// covers the filter and null cases, zero lengths, bare end markers and
// saturation; random streams under both null modes follow, with random
// backpressure, a long output hold-off and full-rate stretches.
// ----------------------------------------------------------------------------
module run_end_filter_coalescer_core_tb;
	import refc_pkg::*;

	localparam int RUN_END_W   = RUN_END_BITS_DEF;
	localparam int RUN_TDATA_W = ((RUN_END_W + VALUE_WORD_W + 7) / 8) * 8;
	localparam int SETTLE      = 10;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic {
		NM_DROP = 1'b0,
		NM_EMIT = 1'b1
	} null_mode_e;

	typedef struct {
		logic [VALUE_WORD_W-1:0] value_word;
		logic                    value_valid;
		logic [SEG_LEN_W-1:0]    seg_len;
		logic                    filter_valid;
		logic                    filter_select;
		logic                    last_segment;
	} segment_t;

	typedef struct {
		logic [RUN_END_W-1:0]    run_end;
		logic [VALUE_WORD_W-1:0] run_value;
		logic                    run_valid;
		logic                    has_run;
		logic                    end_of_stream;
		logic                    last_of_item;
		logic                    overflow;
	} run_t;

	// Coalescing model plus the queue of runs still owed by the block.
	class run_scoreboard;
		run_t                    pending_runs[$];
		null_mode_e              mode;
		int unsigned             fail_count;
		logic [RUN_END_W-1:0]    open_len;
		logic                    open_null;
		logic [VALUE_WORD_W-1:0] open_val;
		logic [RUN_END_W-1:0]    end_so_far;
		logic                    ovf;

		function new();
			mode = NM_DROP;
			fail_count = 0;
			clear_runs();
		endfunction

		function void clear_runs();
			open_len = '0;
			open_null = 1'b1;
			open_val = '0;
			end_so_far = '0;
			ovf = 1'b0;
		endfunction

		function logic [RUN_END_W-1:0] add_sat(logic [RUN_END_W-1:0] a,
				logic [RUN_END_W-1:0] b);
			logic [RUN_END_W:0] sum;
			sum = {1'b0, a} + {1'b0, b};
			if (sum[RUN_END_W]) begin
				ovf = 1'b1;
				return '1;
			end
			return sum[RUN_END_W-1:0];
		endfunction

		function run_t make_run(logic has, logic valid, logic [VALUE_WORD_W-1:0] value,
				logic eos);
			run_t r;
			r.run_end = end_so_far;
			r.run_valid = has && valid;
			r.run_value = r.run_valid ? value : '0;
			r.has_run = has;
			r.end_of_stream = eos;
			r.last_of_item = 1'b0;
			r.overflow = ovf;
			return r;
		endfunction

		// Closes the open run if it holds any length.
		function bit close_open(ref run_t batch[$], input logic eos);
			if (open_len == 0)
				return 1'b0;
			end_so_far = add_sat(end_so_far, open_len);
			batch.push_back(make_run(1'b1, !open_null, open_val, eos));
			return 1'b1;
		endfunction

		function void note_segment(segment_t sg);
			run_t batch[$];
			logic take, fnull, is_null;
			if (sg.filter_valid) begin
				take = sg.filter_select;
				fnull = 1'b0;
			end else begin
				take = (mode == NM_EMIT);
				fnull = 1'b1;
			end
			if (take && sg.seg_len != 0) begin
				is_null = fnull || !sg.value_valid;
				if (is_null) begin
					if (open_null) begin
						open_len = add_sat(open_len, sg.seg_len);
					end else begin
						void'(close_open(batch, 1'b0));
						open_len = sg.seg_len;
						open_null = 1'b1;
					end
				end else if (open_null || open_len == 0 || open_val != sg.value_word) begin
					void'(close_open(batch, 1'b0));
					open_len = sg.seg_len;
					open_null = 1'b0;
					open_val = sg.value_word;
				end else begin
					open_len = add_sat(open_len, sg.seg_len);
				end
			end
			if (sg.last_segment) begin
				if (!close_open(batch, 1'b1))
					batch.push_back(make_run(1'b0, 1'b0, '0, 1'b1));
				clear_runs();
			end
			if (batch.size() > 0)
				batch[batch.size()-1].last_of_item = 1'b1;
			foreach (batch[i])
				pending_runs.push_back(batch[i]);
		endfunction

		function void cmp(string name, logic [VALUE_WORD_W-1:0] want,
				logic [VALUE_WORD_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_run(run_t got);
			run_t want;
			if (pending_runs.size() == 0) begin
				$error("run transfer with nothing pending: run_end %0h", got.run_end);
				fail_count++;
				return;
			end
			want = pending_runs.pop_front();
			cmp("run_end", VALUE_WORD_W'(want.run_end), VALUE_WORD_W'(got.run_end));
			cmp("run_value", want.run_value, got.run_value);
			cmp("run_valid", VALUE_WORD_W'(want.run_valid), VALUE_WORD_W'(got.run_valid));
			cmp("has_run", VALUE_WORD_W'(want.has_run), VALUE_WORD_W'(got.has_run));
			cmp("end_of_stream", VALUE_WORD_W'(want.end_of_stream),
				VALUE_WORD_W'(got.end_of_stream));
			cmp("last_of_item", VALUE_WORD_W'(want.last_of_item),
				VALUE_WORD_W'(got.last_of_item));
			cmp("overflow", VALUE_WORD_W'(want.overflow), VALUE_WORD_W'(got.overflow));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // value_word[63:0], segment_length[95:64]
	logic [IN_TUSER_W-1:0]  s_tuser;   // value_valid, filter_valid, filter_select
	logic                   s_tlast;   // last_segment
	logic                   m_tvalid;
	logic                   m_tready;
	logic [RUN_TDATA_W-1:0] m_tdata;   // run_end, run_value (64), zero fill
	logic [OUT_TUSER_W-1:0] m_tuser;   // run_valid, has_run, last_of_item, overflow
	logic                   m_tlast;   // end_of_stream

	run_scoreboard sb;
	bit            steady;
	bit            hold_req;

	run_end_filter_coalescer_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("run_end_filter_coalescer_core test failed");
		$finish;
	end

	function automatic segment_t seg_of(logic [63:0] value, logic vv, logic [31:0] len,
			logic fv, logic fs, logic last);
		segment_t sg;
		sg.value_word = value;
		sg.value_valid = vv;
		sg.seg_len = len;
		sg.filter_valid = fv;
		sg.filter_select = fs;
		sg.last_segment = last;
		return sg;
	endfunction

	// Random idle gap, then one segment transfer. Valid stays high afterwards so
	// that back-to-back segments need no extra assignment.
	task automatic feed(segment_t sg);
		if (!steady) begin
			while ($urandom_range(99) < 28) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tdata <= {sg.seg_len, sg.value_word};
		s_tuser <= {sg.filter_select, sg.filter_valid, sg.value_valid};
		s_tlast <= sg.last_segment;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_segment(sg);
	endtask

	// Waits until every owed run has come out, then lets the pipeline settle,
	// since a segment that causes no run may still be in flight.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_runs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_null_mode(null_mode_e m);
		cfg_data <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.mode = m;
	endtask

	function automatic logic [31:0] pick_len();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		if (roll < 85)
			return $urandom_range(20, 1);
		if (roll < 95)
			return $urandom;
		return 32'hFFFF_FFFF - $urandom_range(15);
	endfunction

	// Mostly complete streams over a small value pool so that runs merge;
	// the rest is unrelated noise and streams cut off without a last segment.
	task automatic random_streams(int unsigned count);
		logic [63:0] pool[4];
		logic [63:0] value;
		int unsigned done, span;
		bit          cut;
		done = 0;
		while (done < count) begin
			if ($urandom_range(99) < 10) begin
				feed(seg_of({$urandom, $urandom}, 1'($urandom_range(1)), $urandom,
					1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1))));
				done++;
			end else begin
				foreach (pool[i])
					case ($urandom_range(5))
						0: pool[i] = '0;
						1: pool[i] = '1;
						default: pool[i] = {$urandom, $urandom};
					endcase
				span = $urandom_range(16, 1);
				cut = ($urandom_range(99) < 10);
				value = pool[0];
				for (int unsigned k = 0; k < span; k++) begin
					if ($urandom_range(1))
						value = pool[$urandom_range(3)];
					feed(seg_of(value, $urandom_range(99) < 85, pick_len(),
						$urandom_range(99) < 85, $urandom_range(99) < 70,
						(k == span - 1) && !cut));
				end
				done += span;
			end
		end
	endtask

	// Output side: checks each run transfer and drives the ready with random
	// stalls, a long hold-off on request, or full rate while steady is set.
	initial begin : run_sink
		int unsigned hold_left;
		run_t        got;
		out_flags_t  fl;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				fl = out_flags_t'(m_tuser);
				got.run_end = m_tdata[RUN_END_W-1:0];
				got.run_value = m_tdata[RUN_END_W +: VALUE_WORD_W];
				got.run_valid = fl.run_valid;
				got.has_run = fl.has_run;
				got.last_of_item = fl.last_of_item;
				got.overflow = fl.overflow;
				got.end_of_stream = m_tlast;
				sb.check_run(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 28);
			end
		end
	end

	initial begin : stimulus
		null_mode_e plan[4];
		sb = new();
		steady = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Null mode from reset: drop segments whose filter bit is null.
		feed(seg_of('0, 1'b1, 32'd0, 1'b1, 1'b1, 1'b1));             // bare end marker only
		feed(seg_of('0, 1'b1, 32'd1, 1'b1, 1'b1, 1'b0));
		feed(seg_of('0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));     // open run saturates
		feed(seg_of('1, 1'b1, 32'd5, 1'b1, 1'b1, 1'b0));
		feed(seg_of(64'hDEAD_BEEF, 1'b0, 32'd3, 1'b1, 1'b1, 1'b1));  // null tail, two runs
		feed(seg_of(64'h1234, 1'b1, 32'd7, 1'b1, 1'b0, 1'b0));       // not selected
		feed(seg_of(64'h1234, 1'b1, 32'd4, 1'b0, 1'b1, 1'b0));       // null filter, dropped
		feed(seg_of(64'hA5A5, 1'b1, 32'd2, 1'b1, 1'b1, 1'b0));
		feed(seg_of(64'hA5A5, 1'b1, 32'd3, 1'b1, 1'b1, 1'b0));
		feed(seg_of(64'hA5A5, 1'b0, 32'd1, 1'b1, 1'b1, 1'b0));       // null value closes run
		feed(seg_of(64'h5A5A, 1'b0, 32'd2, 1'b1, 1'b1, 1'b0));
		feed(seg_of(64'h0BAD, 1'b1, 32'd0, 1'b1, 1'b1, 1'b0));       // zero length ignored
		feed(seg_of(64'h0BAD, 1'b1, 32'd1, 1'b1, 1'b1, 1'b1));
		drain();

		// Null filter bits now become null runs.
		write_null_mode(NM_EMIT);
		feed(seg_of(64'hFACE, 1'b1, 32'd5, 1'b0, 1'b0, 1'b0));
		feed(seg_of(64'hFACE, 1'b1, 32'd2, 1'b0, 1'b1, 1'b0));
		feed(seg_of(64'hFACE, 1'b1, 32'd1, 1'b1, 1'b1, 1'b0));
		feed(seg_of(64'hFACE, 1'b1, 32'd9, 1'b1, 1'b0, 1'b0));
		feed(seg_of(64'hFACE, 1'b1, 32'd2, 1'b1, 1'b1, 1'b0));
		feed(seg_of(64'hFACE, 1'b1, 32'd0, 1'b0, 1'b1, 1'b1));       // zero-length flush
		feed(seg_of(64'h7777, 1'b1, 32'd1, 1'b0, 1'b0, 1'b1));
		drain();

		plan = '{NM_DROP, NM_EMIT, NM_EMIT, NM_DROP};
		foreach (plan[p]) begin
			write_null_mode(plan[p]);
			steady = (p == 1);
			if (p == 2)
				hold_req = 1'b1;
			random_streams(175);
			drain();
			steady = 1'b0;
		end

		if (sb.fail_count == 0)
			$display("run_end_filter_coalescer_core test passed");
		else
			$display("run_end_filter_coalescer_core test failed");
		$finish;
	end

endmodule
